>>> src/rotated_rectangle_vertices_assert.svh
// Assertion shorthands for the rectangle corner block.
// Each expects clk and rst in scope; rst masks the check.
`ifndef ROTATED_RECTANGLE_VERTICES_ASSERT_SVH
`define ROTATED_RECTANGLE_VERTICES_ASSERT_SVH

// pre true at an edge implies post at the same edge
`define RRV_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// pre true at an edge implies post at the following edge
`define RRV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> src/rrv_pkg.sv
`default_nettype none
package rrv_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 24;

  localparam int TRIG_W  = 32;  // Q2.30 sine/cosine
  localparam int CORD_W  = 34;  // CORDIC x/y/z with headroom
  localparam int COEF_FRAC  = ((62 - COORD_WIDTH) < 30) ? (62 - COORD_WIDTH) : 30;
  localparam int COEF_SHIFT = 30 - COEF_FRAC;
  localparam int COEF_W  = 34;
  localparam int PROD_W  = COEF_W + COORD_WIDTH;
  localparam int SUM_W   = PROD_W + 2;
  localparam int COEF_RND = (COEF_SHIFT > 0) ? (1 << (COEF_SHIFT - 1)) : 0;

  localparam logic signed [CORD_W-1:0] TRIG_GAIN = CORD_W'(652032874);
  localparam logic signed [SUM_W-1:0]  CORNER_RND = SUM_W'(1) <<< (COEF_FRAC - 1);

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] angle_alpha;
    logic signed [ANGLE_WIDTH-1:0] angle_beta;
    logic signed [ANGLE_WIDTH-1:0] angle_gamma;
    logic [COORD_WIDTH-2:0]        half_width;
    logic [COORD_WIDTH-2:0]        half_height;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                    corner_index;
    logic signed [COORD_WIDTH-1:0] corner_x;
    logic signed [COORD_WIDTH-1:0] corner_y;
    logic signed [COORD_WIDTH-1:0] corner_z;
    logic signed [COORD_WIDTH-1:0] edge_x;
    logic signed [COORD_WIDTH-1:0] edge_y;
    logic signed [COORD_WIDTH-1:0] edge_z;
    logic                          last_corner;
  } out_item_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sn;
    logic signed [TRIG_W-1:0] cs;
  } trig_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] kxy;
    logic signed [COEF_W-1:0] kxx;
    logic signed [COEF_W-1:0] kyy;
    logic signed [COEF_W-1:0] kyx;
    logic signed [COEF_W-1:0] kzy;
    logic signed [COEF_W-1:0] kzx;
  } coef_t;

  typedef struct packed {
    logic [COORD_WIDTH-2:0]        hw;
    logic [COORD_WIDTH-2:0]        hh;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
  } side_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } vec_t;

  // arctan(2^-i) in phase units, full turn = 2^32
  function automatic logic [31:0] arc_tab(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10680350;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Q2.30 product, rounded half up
  function automatic logic signed [TRIG_W-1:0] qmul(input logic signed [TRIG_W-1:0] a,
                                                   input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b + (64'sd1 <<< 29);
    return p[TRIG_W+29:30];
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_rnd(input logic signed [COEF_W-1:0] v);
    logic signed [COEF_W-1:0] r;
    r = v + COEF_W'(COEF_RND);
    return r >>> COEF_SHIFT;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[COORD_WIDTH-1:0];
    if (v < lo) return lo[COORD_WIDTH-1:0];
    return v[COORD_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/rrv_cordic.sv
`default_nettype none
// Angle fold, pipelined CORDIC, quadrant fix.
module rrv_cordic #(
  parameter int STAGES = rrv_pkg::CORDIC_STAGES
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [rrv_pkg::ANGLE_WIDTH-1:0] angle,
  output rrv_pkg::trig_t                         trig
);

  localparam int W = rrv_pkg::CORD_W;

  logic [31:0] phase;
  logic [31:0] qsum;
  logic [1:0]  q0;
  logic [31:0] res;

  logic signed [W-1:0] x [0:STAGES];
  logic signed [W-1:0] y [0:STAGES];
  logic signed [W-1:0] z [0:STAGES];
  logic [1:0]          qd [0:STAGES];

  always_comb begin
    phase = {angle, {(32-rrv_pkg::ANGLE_WIDTH){1'b0}}};
    qsum  = phase + 32'h2000_0000;
    q0    = qsum[31:30];
    res   = phase - {q0, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= rrv_pkg::TRIG_GAIN;
      y[0]  <= '0;
      z[0]  <= W'(signed'(res));
      qd[0] <= q0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] at;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    assign at = W'(rrv_pkg::arc_tab(i));
    always_ff @(posedge clk) begin
      if (en) begin
        qd[i+1] <= qd[i];
        if (!z[i][W-1]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - at;
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + at;
        end
      end
    end
  end

  // quarter-turn rotation of (cos, sin)
  always_ff @(posedge clk) begin
    if (en) begin
      case (qd[STAGES])
        2'd0: begin
          trig.cs <= rrv_pkg::TRIG_W'(x[STAGES]);
          trig.sn <= rrv_pkg::TRIG_W'(y[STAGES]);
        end
        2'd1: begin
          trig.cs <= rrv_pkg::TRIG_W'(-y[STAGES]);
          trig.sn <= rrv_pkg::TRIG_W'(x[STAGES]);
        end
        2'd2: begin
          trig.cs <= rrv_pkg::TRIG_W'(-x[STAGES]);
          trig.sn <= rrv_pkg::TRIG_W'(-y[STAGES]);
        end
        default: begin
          trig.cs <= rrv_pkg::TRIG_W'(y[STAGES]);
          trig.sn <= rrv_pkg::TRIG_W'(-x[STAGES]);
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/rrv_coef.sv
`default_nettype none
// Rotation coefficients from three sine/cosine pairs.
module rrv_coef (
  input  logic           clk,
  input  logic           en,
  input  rrv_pkg::trig_t ta,
  input  rrv_pkg::trig_t tb,
  input  rrv_pkg::trig_t tc,
  output rrv_pkg::coef_t coef
);

  localparam int T = rrv_pkg::TRIG_W;
  localparam int C = rrv_pkg::COEF_W;

  logic signed [T-1:0] sasb, cacc, sasc, sbsc, casb, ccsa, cbsc, ca1, cb1;
  logic signed [T-1:0] t1, t2, sasb2, cacc2, sbsc2, casb2, ccsa2, cb2;

  always_ff @(posedge clk) begin
    if (en) begin
      sasb <= rrv_pkg::qmul(ta.sn, tb.sn);
      cacc <= rrv_pkg::qmul(ta.cs, tc.cs);
      sasc <= rrv_pkg::qmul(ta.sn, tc.sn);
      sbsc <= rrv_pkg::qmul(tb.sn, tc.sn);
      casb <= rrv_pkg::qmul(ta.cs, tb.sn);
      ccsa <= rrv_pkg::qmul(tc.cs, ta.sn);
      cbsc <= rrv_pkg::qmul(tb.cs, tc.sn);
      ca1  <= ta.cs;
      cb1  <= tb.cs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1    <= rrv_pkg::qmul(cb1, sasc);
      t2    <= rrv_pkg::qmul(ca1, cbsc);
      sasb2 <= sasb;
      cacc2 <= cacc;
      sbsc2 <= sbsc;
      casb2 <= casb;
      ccsa2 <= ccsa;
      cb2   <= cb1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef.kxy <= rrv_pkg::coef_rnd(C'(sasb2));
      coef.kxx <= rrv_pkg::coef_rnd(C'(cacc2) - C'(t1));
      coef.kyy <= rrv_pkg::coef_rnd(C'(cb2));
      coef.kyx <= rrv_pkg::coef_rnd(C'(sbsc2));
      coef.kzy <= rrv_pkg::coef_rnd(C'(casb2));
      coef.kzx <= rrv_pkg::coef_rnd(C'(ccsa2) + C'(t2));
    end
  end

endmodule
`default_nettype wire

>>> src/rrv_corner.sv
`default_nettype none
// Corner points and edges: products, sums, center add, edge diff, each registered.
module rrv_corner (
  input  logic                 clk,
  input  logic                 en,
  input  rrv_pkg::coef_t       coef,
  input  rrv_pkg::side_t       side,
  output rrv_pkg::vec_t  [3:0] pt,
  output rrv_pkg::vec_t  [3:0] ed
);

  localparam int P  = rrv_pkg::PROD_W;
  localparam int S  = rrv_pkg::SUM_W;
  localparam int CW = rrv_pkg::COORD_WIDTH;

  logic signed [CW-1:0] hw_s, hh_s;
  logic signed [P-1:0]  ax, bx, ay, by, az, bz;
  logic signed [CW-1:0] c1x, c1y, c1z, c2x, c2y, c2z;
  logic signed [S-1:0]  rx [0:3];
  logic signed [S-1:0]  ry [0:3];
  logic signed [S-1:0]  rz [0:3];
  logic signed [S-1:0]  rx_next [0:3];
  logic signed [S-1:0]  ry_next [0:3];
  logic signed [S-1:0]  rz_next [0:3];
  rrv_pkg::vec_t [3:0]  p2;

  assign hw_s = signed'({1'b0, side.hw});
  assign hh_s = signed'({1'b0, side.hh});

  always_ff @(posedge clk) begin
    if (en) begin
      ax  <= coef.kxy * hh_s;
      bx  <= coef.kxx * hw_s;
      ay  <= coef.kyy * hh_s;
      by  <= coef.kyx * hw_s;
      az  <= coef.kzy * hh_s;
      bz  <= coef.kzx * hw_s;
      c1x <= side.cx;
      c1y <= side.cy;
      c1z <= side.cz;
    end
  end

  // corner k: x sign + - - +, y sign + + - -
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic sx;
      logic sy;
      logic signed [S-1:0] tyx, txx, tyy, txy, tyz, txz;
      sx  = (k == 0) || (k == 3);
      sy  = (k < 2);
      tyx = sy ? S'(ax) : -S'(ax);
      txx = sx ? S'(bx) : -S'(bx);
      tyy = sy ? S'(ay) : -S'(ay);
      txy = sx ? S'(by) : -S'(by);
      tyz = sy ? S'(az) : -S'(az);
      txz = sx ? S'(bz) : -S'(bz);
      rx_next[k] = (tyx + txx + rrv_pkg::CORNER_RND) >>> rrv_pkg::COEF_FRAC;
      ry_next[k] = (tyy + txy + rrv_pkg::CORNER_RND) >>> rrv_pkg::COEF_FRAC;
      rz_next[k] = (tyz - txz + rrv_pkg::CORNER_RND) >>> rrv_pkg::COEF_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        rx[k] <= rx_next[k];
        ry[k] <= ry_next[k];
        rz[k] <= rz_next[k];
      end
      c2x <= c1x;
      c2y <= c1y;
      c2z <= c1z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p2[k].x <= rrv_pkg::sat_coord(rx[k] + S'(c2x));
        p2[k].y <= rrv_pkg::sat_coord(ry[k] + S'(c2y));
        p2[k].z <= rrv_pkg::sat_coord(rz[k] + S'(c2z));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        pt[k]   <= p2[k];
        ed[k].x <= rrv_pkg::sat_coord(S'(p2[k].x) - S'(p2[(k+1)%4].x));
        ed[k].y <= rrv_pkg::sat_coord(S'(p2[k].y) - S'(p2[(k+1)%4].y));
        ed[k].z <= rrv_pkg::sat_coord(S'(p2[k].z) - S'(p2[(k+1)%4].z));
      end
    end
  end

endmodule
`default_nettype wire

>>> src/rotated_rectangle_vertices.sv
`default_nettype none
// Rectangle corner generator. Each element (three yxy Euler angles as 16-bit
// binary angles, Q8.24 half width/height and center) yields four vert items,
// corners (+w,+h), (-w,+h), (-w,-h), (+w,-h), each with an edge equal to it
// minus the next corner; last_corner marks the fourth. Corners and edges
// saturate to 32 bits. Throughput is set by the single vert channel carrying
// four corners per element, while vert_stall is low; elements enter while
// earlier ones are in flight. From accept to first corner an element passes
// the sine/cosine CORDIC stages, coefficient stages, corner and edge stages and
// the output buffer. The whole pipeline holds when its last stage is full and
// the buffer cannot take it, so stalls drop or repeat nothing.
module rotated_rectangle_vertices #(
  parameter int CORDIC_STAGES = rrv_pkg::CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               elem_valid,
  output logic               elem_stall,
  input  rrv_pkg::in_item_t  elem,
  output logic               vert_valid,
  input  logic               vert_stall,
  output rrv_pkg::out_item_t vert
);

  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  localparam int SIDE_DEPTH = CORDIC_LAT + 3;
  localparam int PIPE_LAT   = SIDE_DEPTH + 4;

  logic                  adv;       // whole pipeline steps
  logic                  buf_load;
  logic [PIPE_LAT-1:0]   vld;
  rrv_pkg::side_t        side_q [0:SIDE_DEPTH-1];
  rrv_pkg::trig_t        ta, tb, tc;
  rrv_pkg::coef_t        coef;
  rrv_pkg::vec_t [3:0]   pt, ed;

  // output buffer: one element's four corners
  rrv_pkg::vec_t [3:0]   hpt, hed;
  logic [1:0]            cnt;
  logic                  busy;

  assign buf_load   = vld[PIPE_LAT-1] && (!busy || ((cnt == 2'd3) && !vert_stall));
  assign adv        = !vld[PIPE_LAT-1] || buf_load;
  assign elem_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], elem_valid};
    end
  end

  // sizes and center ride alongside the trig/coefficient stages
  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= '{hw: elem.half_width, hh: elem.half_height,
                     cx: elem.center_x, cy: elem.center_y, cz: elem.center_z};
      for (int i = 1; i < SIDE_DEPTH; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  rrv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_a (
    .clk(clk), .en(adv), .angle(elem.angle_alpha), .trig(ta));
  rrv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_b (
    .clk(clk), .en(adv), .angle(elem.angle_beta), .trig(tb));
  rrv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_c (
    .clk(clk), .en(adv), .angle(elem.angle_gamma), .trig(tc));

  rrv_coef u_coef (
    .clk(clk), .en(adv), .ta(ta), .tb(tb), .tc(tc), .coef(coef));

  rrv_corner u_corner (
    .clk(clk), .en(adv), .coef(coef), .side(side_q[SIDE_DEPTH-1]), .pt(pt), .ed(ed));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (buf_load) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
    end else if (busy && !vert_stall) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (buf_load) begin
      hpt <= pt;
      hed <= ed;
    end
  end

  assign vert_valid = busy;

  always_comb begin
    vert.corner_index = cnt;
    vert.corner_x     = hpt[cnt].x;
    vert.corner_y     = hpt[cnt].y;
    vert.corner_z     = hpt[cnt].z;
    vert.edge_x       = hed[cnt].x;
    vert.edge_y       = hed[cnt].y;
    vert.edge_z       = hed[cnt].z;
    vert.last_corner  = (cnt == 2'd3);
  end

endmodule
`default_nettype wire

>>> src/rrv_checker.sv
`default_nettype none
`include "rotated_rectangle_vertices_assert.svh"
module rrv_checker (
  input logic               clk,
  input logic               rst,
  input logic               elem_valid,
  input logic               elem_stall,
  input rrv_pkg::in_item_t  elem,
  input logic               vert_valid,
  input logic               vert_stall,
  input rrv_pkg::out_item_t vert
);

  `RRV_ASSERT_NOW(a_last_flag, vert_valid, vert.last_corner == (vert.corner_index == 2'd3), "last_corner does not match corner 3")
  `RRV_ASSERT_NEXT(a_corner_seq, vert_valid && !vert_stall && (vert.corner_index != 2'd3), vert_valid && (vert.corner_index == 2'($past(vert.corner_index) + 2'd1)), "corners of an element not back to back in order")
  `RRV_ASSERT_NEXT(a_vert_hold, vert_valid && vert_stall, vert_valid && $stable(vert), "stalled vert changed")

endmodule

bind rotated_rectangle_vertices rrv_checker u_rrv_checker (.*);
`default_nettype wire
